@@ rtl/core/tfn_pkg.sv @@
package tfn_pkg;

    // Request: one triangle, signed Q8.8 vertices
    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] bx;
        logic signed [15:0] by_coord;
        logic signed [15:0] bz;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] cz;
    } t_req;

    // Result: unit normal, Q1.14
    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic        [14:0] normal_z;
        logic               degenerate;
    } t_rsp;

    localparam int MAG_W  = 34;   // |cross product| bits
    localparam int ACC_W  = 68;   // root search accumulator bits
    localparam int Q_W    = 15;   // Q1.14 magnitude bits
    localparam int Q_TOP  = 14;   // first search bit (value one)

    // Cross product magnitudes and output sign flags
    typedef struct packed {
        logic               valid;
        logic               neg_x;
        logic               neg_y;
        logic [MAG_W-1:0]   ux;
        logic [MAG_W-1:0]   uy;
        logic [MAG_W-1:0]   uz;
    } t_mag;

    // One lane of the digit-by-digit search
    typedef struct packed {
        logic signed [ACC_W-1:0] r;   // 2^30 v^2 - (2q-1)^2 S
        logic signed [ACC_W-1:0] p;   // (2q-1) S
        logic        [Q_W-1:0]   q;
    } t_lane;

    typedef struct packed {
        logic               valid;
        logic               neg_x;
        logic               neg_y;
        logic               degen;
        logic [MAG_W-1:0]   s;
        t_lane              lx;
        t_lane              ly;
        t_lane              lz;
    } t_root;

    // Try setting bit b of q: keep it when q is still below one and (2t-1)^2 S still fits under 2^30 v^2
    function automatic t_lane root_lane(t_lane l, logic [MAG_W-1:0] s, logic [3:0] b);
        logic signed [ACC_W-1:0] sx;
        logic signed [ACC_W-1:0] term;
        logic signed [ACC_W-1:0] diff;
        t_lane                   o;
        sx   = $signed({{(ACC_W-MAG_W){1'b0}}, s});
        term = (l.p <<< ({1'b0, b} + 5'd2)) + (sx <<< ({b, 1'b0} + 5'd2));
        diff = l.r - term;
        o    = l;
        if (!l.q[Q_TOP] && !diff[ACC_W-1]) begin
            o.r = diff;
            o.p = l.p + (sx <<< ({1'b0, b} + 5'd1));
            o.q = l.q | (Q_W'(1) << b);
        end
        return o;
    endfunction

endpackage

@@ rtl/core/tfn_cross.sv @@
module tfn_cross (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  tfn_pkg::t_req  i_req,
    output tfn_pkg::t_mag  o_mag
);

    logic                r_v1, r_v2, r_v3;
    logic signed [16:0]  r_e1x, r_e1y, r_e1z, r_e2x, r_e2y, r_e2z;
    logic signed [33:0]  r_m0, r_m1, r_m2, r_m3, r_m4, r_m5;
    logic signed [34:0]  r_kx, r_ky, r_kz;
    tfn_pkg::t_mag       r_mag;
    logic signed [34:0]  n_ax, n_ay, n_az;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_mag.valid <= 1'b0;
        end else begin
            r_v1        <= i_valid;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_mag.valid <= r_v3;
        end
    end

    // magnitudes of K
    always_comb begin
        n_ax = r_kx[34] ? -r_kx : r_kx;
        n_ay = r_ky[34] ? -r_ky : r_ky;
        n_az = r_kz[34] ? -r_kz : r_kz;
    end

    // edges, products, cross product, magnitude
    always_ff @(posedge i_clk) begin
        r_e1x <= 17'(i_req.bx) - 17'(i_req.ax);
        r_e1y <= 17'(i_req.by_coord) - 17'(i_req.ay);
        r_e1z <= 17'(i_req.bz) - 17'(i_req.az);
        r_e2x <= 17'(i_req.cx) - 17'(i_req.ax);
        r_e2y <= 17'(i_req.cy) - 17'(i_req.ay);
        r_e2z <= 17'(i_req.cz) - 17'(i_req.az);

        r_m0 <= r_e1y * r_e2z;
        r_m1 <= r_e1z * r_e2y;
        r_m2 <= r_e1z * r_e2x;
        r_m3 <= r_e1x * r_e2z;
        r_m4 <= r_e1x * r_e2y;
        r_m5 <= r_e1y * r_e2x;

        r_kx <= 35'(r_m0) - 35'(r_m1);
        r_ky <= 35'(r_m2) - 35'(r_m3);
        r_kz <= 35'(r_m4) - 35'(r_m5);

        // normal is flipped when K_z is negative
        r_mag.neg_x <= r_kx[34] ^ r_kz[34];
        r_mag.neg_y <= r_ky[34] ^ r_kz[34];
        r_mag.ux    <= n_ax[33:0];
        r_mag.uy    <= n_ay[33:0];
        r_mag.uz    <= n_az[33:0];
    end

    assign o_mag = r_mag;

endmodule

@@ rtl/core/tfn_prep.sv @@
module tfn_prep (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tfn_pkg::t_mag  i_mag,
    output tfn_pkg::t_root o_root
);

    logic                       r_v5, r_v6, r_v7, r_v8;
    logic [tfn_pkg::MAG_W-1:0]  r_ux, r_uy, r_uz;
    logic [4:0]                 r_sh;
    logic                       r_nx5, r_ny5, r_nx6, r_ny6, r_nx7, r_ny7, r_nx8, r_ny8;
    logic                       r_dg6, r_dg7, r_dg8;
    logic [15:0]                r_vx, r_vy, r_vz;
    logic [31:0]                r_qx, r_qy, r_qz;
    logic [31:0]                r_sqx, r_sqy, r_sqz;
    logic [tfn_pkg::MAG_W-1:0]  r_s;
    tfn_pkg::t_root             r_root;
    logic [tfn_pkg::MAG_W-1:0]  n_mx;
    logic [5:0]                 n_pos;
    logic [4:0]                 n_sh;
    logic signed [tfn_pkg::ACC_W-1:0] n_sx;

    // largest magnitude and its leading one
    always_comb begin
        n_mx = i_mag.ux;
        if (i_mag.uy > n_mx) n_mx = i_mag.uy;
        if (i_mag.uz > n_mx) n_mx = i_mag.uz;
        n_pos = '0;
        for (int i = 0; i < tfn_pkg::MAG_W; i++) begin
            if (n_mx[i]) n_pos = 6'(i);
        end
        n_sh = (n_pos > 6'd15) ? 5'(n_pos - 6'd15) : 5'd0;
        n_sx = $signed({{(tfn_pkg::ACC_W-tfn_pkg::MAG_W){1'b0}}, r_s});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5         <= 1'b0;
            r_v6         <= 1'b0;
            r_v7         <= 1'b0;
            r_v8         <= 1'b0;
            r_root.valid <= 1'b0;
        end else begin
            r_v5         <= i_mag.valid;
            r_v6         <= r_v5;
            r_v7         <= r_v6;
            r_v8         <= r_v7;
            r_root.valid <= r_v8;
        end
    end

    always_ff @(posedge i_clk) begin
        // shift amount
        r_ux  <= i_mag.ux;
        r_uy  <= i_mag.uy;
        r_uz  <= i_mag.uz;
        r_sh  <= n_sh;
        r_nx5 <= i_mag.neg_x;
        r_ny5 <= i_mag.neg_y;
        // scale to 16 bits
        r_vx  <= 16'(r_ux >> r_sh);
        r_vy  <= 16'(r_uy >> r_sh);
        r_vz  <= 16'(r_uz >> r_sh);
        r_dg6 <= (r_ux == '0) && (r_uy == '0) && (r_uz == '0);
        r_nx6 <= r_nx5;
        r_ny6 <= r_ny5;
        // squares
        r_qx  <= r_vx * r_vx;
        r_qy  <= r_vy * r_vy;
        r_qz  <= r_vz * r_vz;
        r_dg7 <= r_dg6;
        r_nx7 <= r_nx6;
        r_ny7 <= r_ny6;
        // sum of squares
        r_s   <= 34'(r_qx) + 34'(r_qy) + 34'(r_qz);
        r_sqx <= r_qx;
        r_sqy <= r_qy;
        r_sqz <= r_qz;
        r_dg8 <= r_dg7;
        r_nx8 <= r_nx7;
        r_ny8 <= r_ny7;
        // search start: q = 0
        r_root.neg_x <= r_nx8;
        r_root.neg_y <= r_ny8;
        r_root.degen <= r_dg8;
        r_root.s     <= r_s;
        r_root.lx.r  <= ($signed({36'd0, r_sqx}) <<< 30) - n_sx;
        r_root.ly.r  <= ($signed({36'd0, r_sqy}) <<< 30) - n_sx;
        r_root.lz.r  <= ($signed({36'd0, r_sqz}) <<< 30) - n_sx;
        r_root.lx.p  <= -n_sx;
        r_root.ly.p  <= -n_sx;
        r_root.lz.p  <= -n_sx;
        r_root.lx.q  <= '0;
        r_root.ly.q  <= '0;
        r_root.lz.q  <= '0;
    end

    assign o_root = r_root;

endmodule

@@ rtl/core/tfn_root_step.sv @@
module tfn_root_step (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [3:0]     i_bit,
    input  tfn_pkg::t_root i_root,
    output tfn_pkg::t_root o_root
);

    tfn_pkg::t_root r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root.valid <= 1'b0;
        end else begin
            r_root.valid <= i_root.valid;
        end
    end

    // one result bit for each of the three lanes
    always_ff @(posedge i_clk) begin
        r_root.neg_x <= i_root.neg_x;
        r_root.neg_y <= i_root.neg_y;
        r_root.degen <= i_root.degen;
        r_root.s     <= i_root.s;
        r_root.lx    <= tfn_pkg::root_lane(i_root.lx, i_root.s, i_bit);
        r_root.ly    <= tfn_pkg::root_lane(i_root.ly, i_root.s, i_bit);
        r_root.lz    <= tfn_pkg::root_lane(i_root.lz, i_root.s, i_bit);
    end

    assign o_root = r_root;

endmodule

@@ rtl/core/triangle_face_normal_up.sv @@
// Triangle face normal, turned up.
// Request channel: drive i_req with one triangle (signed Q8.8 vertices) and
// pulse start. busy is always low, so a request is taken at every clock edge
// with start high; one triangle per cycle is sustained.
// Result channel: o_strobe is high for one cycle while o_result holds the
// unit normal in Q1.14 (z never negative) and the degenerate flag.
// Pipeline: 25 register stages from the accepting edge to o_strobe (the first
// loads at the accepting edge): 4 stages form edges, products and |K|, 5 stages
// normalize the scale and sum the squares, 15 stages resolve one magnitude bit
// each, and one output register.
// Throughput: one result per cycle; results leave in request order.
// The receiver cannot stall; every result must be taken when strobed.
// Reset (i_rst_n low, synchronous) clears all valid bits; requests in
// flight are dropped and no strobe follows until new requests arrive.
module triangle_face_normal_up (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  tfn_pkg::t_req  i_req,
    output logic           o_strobe,
    output tfn_pkg::t_rsp  o_result
);

    tfn_pkg::t_mag  w_mag;
    tfn_pkg::t_root w_chain [0:tfn_pkg::Q_W];
    tfn_pkg::t_root w_last;
    logic           r_strobe;
    tfn_pkg::t_rsp  r_result;
    logic [15:0]    n_mx, n_my;
    logic [14:0]    n_mz;

    assign busy = 1'b0;

    tfn_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_req   (i_req),
        .o_mag   (w_mag)
    );

    tfn_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mag   (w_mag),
        .o_root  (w_chain[0])
    );

    // one stage per magnitude bit, most significant first
    for (genvar g = 0; g < tfn_pkg::Q_W; g++) begin : g_step
        tfn_root_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bit   (4'(tfn_pkg::Q_TOP - g)),
            .i_root  (w_chain[g]),
            .o_root  (w_chain[g+1])
        );
    end

    assign w_last = w_chain[tfn_pkg::Q_W];

    // apply signs
    always_comb begin
        n_mx = {1'b0, w_last.lx.q};
        n_my = {1'b0, w_last.ly.q};
        n_mz = w_last.lz.q;
        if (w_last.neg_x) n_mx = -n_mx;
        if (w_last.neg_y) n_my = -n_my;
        // zero cross product: zero normal
        if (w_last.degen) begin
            n_mx = '0;
            n_my = '0;
            n_mz = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result.normal_x   <= $signed(n_mx);
        r_result.normal_y   <= $signed(n_my);
        r_result.normal_z   <= n_mz;
        r_result.degenerate <= w_last.degen;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

@@ dv/tb_triangle_face_normal_up.sv @@
`timescale 1ns / 100ps

module tb_triangle_face_normal_up;

    localparam int LATENCY   = 25;
    localparam longint LIMIT = 400000;

    logic            i_clk;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    tfn_pkg::t_req   i_req;
    logic            o_strobe;
    tfn_pkg::t_rsp   o_result;

    tfn_pkg::t_req   pending_tris[$];
    tfn_pkg::t_rsp   expected_normals[$];
    int              errors = 0;
    int              send_idle_pct;
    bit              hold_for_drain;
    longint          cycle_cnt = 0;

    triangle_face_normal_up uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Largest q <= 16384 with (2q-1)^2 * s <= 2^30 * v^2
    function automatic logic [14:0] unit_component(logic [63:0] v, logic [63:0] s);
        logic [63:0] rhs;
        logic [63:0] q;
        logic [63:0] t;
        logic [63:0] d;
        rhs = (v * v) << 30;
        q   = '0;
        for (int b = 14; b >= 0; b--) begin
            t = q | (64'd1 << b);
            if (t <= 64'd16384) begin
                d = 2 * t - 1;
                if (d * d * s <= rhs) q = t;
            end
        end
        return q[14:0];
    endfunction

    function automatic tfn_pkg::t_rsp face_normal(tfn_pkg::t_req t);
        longint e1x, e1y, e1z, e2x, e2y, e2z, kx, ky, kz;
        logic [63:0] ux, uy, uz, mx, s;
        logic [15:0] mag;
        bit flip;
        tfn_pkg::t_rsp r;
        e1x = longint'(t.bx) - longint'(t.ax);
        e1y = longint'(t.by_coord) - longint'(t.ay);
        e1z = longint'(t.bz) - longint'(t.az);
        e2x = longint'(t.cx) - longint'(t.ax);
        e2y = longint'(t.cy) - longint'(t.ay);
        e2z = longint'(t.cz) - longint'(t.az);
        kx = e1y * e2z - e1z * e2y;
        ky = e1z * e2x - e1x * e2z;
        kz = e1x * e2y - e1y * e2x;
        r = '0;
        if (kx == 0 && ky == 0 && kz == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        ux = (kx < 0) ? -kx : kx;
        uy = (ky < 0) ? -ky : ky;
        uz = (kz < 0) ? -kz : kz;
        mx = ux;
        if (uy > mx) mx = uy;
        if (uz > mx) mx = uz;
        while (mx >= 64'd65536) begin
            mx = mx >> 1;
            ux = ux >> 1;
            uy = uy >> 1;
            uz = uz >> 1;
        end
        s = ux * ux + uy * uy + uz * uz;
        flip = kz < 0;
        mag = {1'b0, unit_component(ux, s)};
        r.normal_x = ((kx < 0) != flip) ? -mag : mag;
        mag = {1'b0, unit_component(uy, s)};
        r.normal_y = ((ky < 0) != flip) ? -mag : mag;
        r.normal_z = unit_component(uz, s);
        return r;
    endfunction

    function automatic tfn_pkg::t_req tri_of(int a0, int a1, int a2, int b0, int b1, int b2,
                                             int c0, int c1, int c2);
        tfn_pkg::t_req t;
        t.ax = 16'(a0); t.ay = 16'(a1); t.az = 16'(a2);
        t.bx = 16'(b0); t.by_coord = 16'(b1); t.bz = 16'(b2);
        t.cx = 16'(c0); t.cy = 16'(c1); t.cz = 16'(c2);
        return t;
    endfunction

    // Add one request to the pending list
    function automatic void queue_tri(tfn_pkg::t_req t);
        pending_tris = {pending_tris, t};
    endfunction

    // Random triangle: fully random, small around a random anchor, collinear or coincident, or in an axis-aligned plane
    function automatic tfn_pkg::t_req random_tri();
        tfn_pkg::t_req t;
        int spread;
        spread = 1 << $urandom_range(15, 1);
        t = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
        case ($urandom_range(3, 0))
            0: ;
            1: begin
                t.bx = 16'(t.ax + $signed($urandom_range(spread - 1, 0)) - spread / 2);
                t.by_coord = 16'(t.ay + $signed($urandom_range(spread - 1, 0)) - spread / 2);
                t.bz = 16'(t.az + $signed($urandom_range(spread - 1, 0)) - spread / 2);
                t.cx = 16'(t.ax + $signed($urandom_range(spread - 1, 0)) - spread / 2);
                t.cy = 16'(t.ay + $signed($urandom_range(spread - 1, 0)) - spread / 2);
                t.cz = 16'(t.az + $signed($urandom_range(spread - 1, 0)) - spread / 2);
            end
            2: begin
                // collinear or coincident
                t.bx = t.ax + 16'($urandom_range(3, 0));
                t.by_coord = t.ay;
                t.bz = t.az + 16'($urandom_range(3, 0));
                t.cx = 16'(t.ax + 2 * (t.bx - t.ax));
                t.cy = t.ay;
                t.cz = 16'(t.az + 2 * (t.bz - t.az));
            end
            default: begin
                // axis-aligned plane, some components exactly zero
                t.bz = t.az;
                t.cz = t.az;
                if ($urandom_range(1, 0)) begin
                    t.by_coord = t.ay;
                    t.cy = t.ay;
                    t.bz = t.az + 16'($urandom);
                end
            end
        endcase
        return t;
    endfunction

    // Request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !busy) begin
            if (pending_tris.size() > 0 && !hold_for_drain &&
                    $urandom_range(99, 0) >= send_idle_pct) begin
                i_req <= pending_tris.pop_front();
            end else begin
                start <= 1'b0;
            end
        end else if (!start && pending_tris.size() > 0 && !hold_for_drain &&
                $urandom_range(99, 0) >= send_idle_pct) begin
            start <= 1'b1;
            i_req <= pending_tris.pop_front();
        end
    end

    // Predict on acceptance, check strobed results
    always @(posedge i_clk) begin
        tfn_pkg::t_rsp exp_r;
        cycle_cnt <= cycle_cnt + 1;
        if (i_rst_n && start && !busy)
            expected_normals = {expected_normals, face_normal(i_req)};
        if (i_rst_n && o_strobe) begin
            if (expected_normals.size() == 0) begin
                $error("result with nothing expected: %h", o_result);
                errors++;
            end else begin
                exp_r = expected_normals.pop_front();
                if (o_result.normal_x !== exp_r.normal_x) begin
                    $error("normal_x exp %0d got %0d", exp_r.normal_x, o_result.normal_x);
                    errors++;
                end
                if (o_result.normal_y !== exp_r.normal_y) begin
                    $error("normal_y exp %0d got %0d", exp_r.normal_y, o_result.normal_y);
                    errors++;
                end
                if (o_result.normal_z !== exp_r.normal_z) begin
                    $error("normal_z exp %0d got %0d", exp_r.normal_z, o_result.normal_z);
                    errors++;
                end
                if (o_result.degenerate !== exp_r.degenerate) begin
                    $error("degenerate exp %0d got %0d", exp_r.degenerate,
                           o_result.degenerate);
                    errors++;
                end
            end
        end
    end

    // Timeout
    always @(posedge i_clk) begin
        if (cycle_cnt > LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_tris.size() > 0 || start || expected_normals.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        send_idle_pct  = 12;
        hold_for_drain = 1'b0;
        i_rst_n        = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, degenerate, zero z, negative z, flip cases
        queue_tri(tri_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_tri(tri_of(-32768, -32768, -32768, -32768, -32768, -32768,
                         -32768, -32768, -32768));
        queue_tri(tri_of(0, 0, 0, 256, 0, 0, 0, 256, 0));
        queue_tri(tri_of(0, 0, 0, 0, 256, 0, 256, 0, 0));
        queue_tri(tri_of(0, 0, 0, 256, 0, 0, 0, 0, 256));
        queue_tri(tri_of(0, 0, 0, 0, 0, 256, 256, 0, 0));
        queue_tri(tri_of(0, 0, 0, 0, 256, 0, 0, 0, 256));
        queue_tri(tri_of(-32768, -32768, -32768, 32767, -32768, -32768,
                         -32768, 32767, -32768));
        queue_tri(tri_of(-32768, -32768, -32768, 32767, 32767, -32768,
                         -32768, 32767, 32767));
        queue_tri(tri_of(32767, 32767, 32767, -32768, 32767, 32767,
                         32767, 32767, -32768));
        queue_tri(tri_of(-32768, 32767, -32768, 32767, -32768, 32767,
                         32767, 32767, -32768));
        queue_tri(tri_of(0, 0, 0, 1, 1, 1, 2, 2, 2));
        queue_tri(tri_of(0, 0, 0, 1, 0, 0, 0, 1, 0));
        queue_tri(tri_of(0, 0, 0, 0, 1, 0, 1, 0, 0));
        queue_tri(tri_of(0, 0, 0, 32767, 1, 0, 1, -32768, 0));
        queue_tri(tri_of(0, 0, 0, 32767, 32767, 1, 32767, 32767, 0));
        queue_tri(tri_of(0, 0, 0, 32767, 32766, 0, 32766, 32767, 1));
        queue_tri(tri_of(-1, -1, -1, -1, -1, -1, 0, 0, 0));
        queue_tri(tri_of(100, -200, 300, 1, 2, 3, -7, 9, -11));
        queue_tri(tri_of(21845, -21846, 10922, -10923, 5461, -5462,
                         13107, -13108, 26214));
        wait_drained();

        // Hold off until the pipe is empty, then random phases
        hold_for_drain = 1'b1;
        for (int i = 0; i < 460; i++) queue_tri(random_tri());
        repeat (3) @(posedge i_clk);
        hold_for_drain = 1'b0;
        wait_drained();

        send_idle_pct = 53;
        for (int i = 0; i < 460; i++) queue_tri(random_tri());
        wait_drained();

        send_idle_pct = 0;
        for (int i = 0; i < 460; i++) queue_tri(random_tri());
        wait_drained();
        repeat (LATENCY + 5) @(posedge i_clk);

        if (errors == 0 && expected_normals.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
